@@ hw/rtl/ptl_pkg.sv @@
// Shared types and constants for the pedestrian traffic light controller.
`default_nettype none
package ptl_pkg;

	localparam int unsigned TIME_W   = 16;
	localparam int unsigned BLINK_W  = 4;
	localparam int unsigned LAMP_N   = 5;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [1:0] PH_RED    = 2'd0;
	localparam logic [1:0] PH_YELLOW = 2'd1;
	localparam logic [1:0] PH_GREEN  = 2'd2;

	localparam int unsigned LAMP_CAR_RED    = 0;
	localparam int unsigned LAMP_CAR_YELLOW = 1;
	localparam int unsigned LAMP_CAR_GREEN  = 2;
	localparam int unsigned LAMP_WALK_GREEN = 3;
	localparam int unsigned LAMP_WALK_RED   = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_RED_TIME     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_TIME  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_TIME   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TOTAL  = 3'd4;

	localparam logic [TIME_W-1:0]  RED_TIME_RST     = 16'd3500;
	localparam logic [TIME_W-1:0]  YELLOW_TIME_RST  = 16'd2000;
	localparam logic [TIME_W-1:0]  GREEN_TIME_RST   = 16'd4000;
	localparam logic [TIME_W-1:0]  BLINK_PERIOD_RST = 16'd500;
	localparam logic [BLINK_W-1:0] BLINK_TOTAL_RST  = 4'd3;

	localparam logic [TIME_W-1:0] ELAPSED_MAX = 16'hFFFF;

	typedef struct packed {
		logic [TIME_W-1:0]  red_time;
		logic [TIME_W-1:0]  yellow_time;
		logic [TIME_W-1:0]  green_time;
		logic [TIME_W-1:0]  blink_period;
		logic [BLINK_W-1:0] blink_total;
	} ptl_cfg_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic               green_flag;
		logic [TIME_W-1:0]  wait_len;
		logic [TIME_W-1:0]  elapsed;
		logic               blinking;
		logic               blink_level;
		logic [BLINK_W-1:0] blink_done;
		logic [LAMP_N-1:0]  lamps;
	} ptl_state_t;

	localparam ptl_state_t STATE_RST = '{
		phase:       PH_RED,
		green_flag:  1'b0,
		wait_len:    '0,
		elapsed:     '0,
		blinking:    1'b0,
		blink_level: 1'b0,
		blink_done:  '0,
		lamps:       '0
	};

endpackage
`default_nettype wire

@@ hw/rtl/ptl_cfg_regs.sv @@
// Configuration register file for the traffic light timings.
`default_nettype none
module ptl_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [ptl_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [ptl_pkg::TIME_W-1:0]     wr_data,
	output ptl_pkg::ptl_cfg_t                   cfg
);

	ptl_pkg::ptl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_time     <= ptl_pkg::RED_TIME_RST;
			cfg_q.yellow_time  <= ptl_pkg::YELLOW_TIME_RST;
			cfg_q.green_time   <= ptl_pkg::GREEN_TIME_RST;
			cfg_q.blink_period <= ptl_pkg::BLINK_PERIOD_RST;
			cfg_q.blink_total  <= ptl_pkg::BLINK_TOTAL_RST;
		end else if (wr_en) begin
			case (wr_index)
				ptl_pkg::CFG_RED_TIME:     cfg_q.red_time     <= wr_data;
				ptl_pkg::CFG_YELLOW_TIME:  cfg_q.yellow_time  <= wr_data;
				ptl_pkg::CFG_GREEN_TIME:   cfg_q.green_time   <= wr_data;
				ptl_pkg::CFG_BLINK_PERIOD: cfg_q.blink_period <= wr_data;
				ptl_pkg::CFG_BLINK_TOTAL:  cfg_q.blink_total  <= wr_data[ptl_pkg::BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ hw/rtl/ptl_step.sv @@
// Next-state and lamp logic for one millisecond tick.
`default_nettype none
module ptl_step (
	input  wire ptl_pkg::ptl_cfg_t   cfg,
	input  wire ptl_pkg::ptl_state_t cur,
	input  wire logic                button,
	output ptl_pkg::ptl_state_t      nxt
);

	logic [1:0]                  ph;
	logic [ptl_pkg::TIME_W-1:0]  wl;
	logic                        service;
	logic                        bl_n;
	logic [ptl_pkg::BLINK_W-1:0] bd_n;

	always_comb begin
		nxt  = cur;
		ph   = cur.phase;
		wl   = cur.wait_len;
		bl_n = ~cur.blink_level;
		bd_n = bl_n ? cur.blink_done : cur.blink_done + 1'b1;
		if (button && cur.green_flag) begin
			ph = ptl_pkg::PH_YELLOW;
			wl = '0;
		end
		service = (cur.elapsed >= wl);
		nxt.phase    = ph;
		nxt.wait_len = wl;
		if (service) begin
			nxt.elapsed = ptl_pkg::TIME_W'(1);
			nxt.lamps   = '0;
			if (ph == ptl_pkg::PH_YELLOW) begin
				nxt.lamps[ptl_pkg::LAMP_WALK_RED]   = 1'b1;
				nxt.lamps[ptl_pkg::LAMP_CAR_YELLOW] = 1'b1;
				nxt.wait_len   = cfg.yellow_time;
				nxt.phase      = cur.green_flag ? ptl_pkg::PH_RED : ptl_pkg::PH_GREEN;
				nxt.green_flag = ~cur.green_flag;
			end else if (ph == ptl_pkg::PH_GREEN) begin
				nxt.lamps[ptl_pkg::LAMP_WALK_RED]  = 1'b1;
				nxt.lamps[ptl_pkg::LAMP_CAR_GREEN] = 1'b1;
				nxt.wait_len = cfg.green_time;
				nxt.phase    = ptl_pkg::PH_YELLOW;
			end else begin
				nxt.lamps[ptl_pkg::LAMP_CAR_RED] = 1'b1;
				if (!cur.blinking) begin
					nxt.lamps[ptl_pkg::LAMP_WALK_GREEN] = 1'b1;
					nxt.wait_len = cfg.red_time;
					nxt.blinking = 1'b1;
				end else begin
					nxt.blink_level = bl_n;
					nxt.lamps[ptl_pkg::LAMP_WALK_RED] = bl_n;
					nxt.wait_len   = cfg.blink_period;
					nxt.blink_done = bd_n;
					if (bd_n >= cfg.blink_total) begin
						nxt.lamps[ptl_pkg::LAMP_WALK_RED] = 1'b1;
						nxt.blink_done  = '0;
						nxt.phase       = ptl_pkg::PH_YELLOW;
						nxt.blinking    = 1'b0;
						nxt.blink_level = 1'b0;
					end
				end
			end
		end else if (cur.elapsed != ptl_pkg::ELAPSED_MAX) begin
			nxt.elapsed = cur.elapsed + 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/pedestrian_traffic_light_fsm_core.sv @@
// Path: an input beat is held in the input register, then in the output register, where it is an output beat.
// Throughput: one tick per cycle; the input register and the output register
// each advance whenever the output register is empty or being drained.
// Reset: arst_n clears both stage valids, the controller state (red phase, lamps off)
// and loads the default timings.
// Top level of the pedestrian traffic light controller.
`default_nettype none
module pedestrian_traffic_light_fsm_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output wire logic                          s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [0] button
	output wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [0] car_red, [1] car_yellow, [2] car_green, [3] walk_green, [4] walk_red
	output wire logic [7:0]                    m_axis_tdata,
	input  wire logic                          cfg_valid,
	output wire logic                          cfg_ready,
	input  wire logic [ptl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ptl_pkg::TIME_W-1:0]    cfg_data
);

	ptl_pkg::ptl_cfg_t   cfg;
	ptl_pkg::ptl_state_t state_q;
	ptl_pkg::ptl_state_t state_nxt;

	logic       valid_s1;
	logic       button_s1;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       advance;

	ptl_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ptl_step u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.button (button_s1),
		.nxt    (state_nxt)
	);

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			button_s1 <= s_axis_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptl_pkg::STATE_RST;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= {3'b000, state_nxt.lamps};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

@@ hw/rtl/ptl_checker.sv @@
// Port-level checks for the pedestrian traffic light controller, with its bind.
`default_nettype none
module ptl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped or changed while stalled");

	a_one_car_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot(m_axis_tdata[2:0]))
		else $error("not exactly one vehicle lamp lit");

	a_walk_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
		else $error("walk and don't-walk lit together");

	a_walk_needs_red: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[0])
		else $error("walk lamp lit without vehicle red");

	a_green_stops_walk: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2] || m_axis_tdata[1]) |-> m_axis_tdata[4])
		else $error("vehicles moving without don't-walk lamp");

endmodule

bind pedestrian_traffic_light_fsm_core ptl_checker u_ptl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ tb/sv/pedestrian_traffic_light_fsm_core_test.sv @@
// Stream testbench for the pedestrian traffic light core: predicts lamps per tick and checks.
module pedestrian_traffic_light_fsm_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ptl_pkg::*;

	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned LONG_HOLD  = 80;
	localparam int unsigned DRAIN_WAIT = 6;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;  // [0] button
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [0] car_red, [1] car_yellow, [2] car_green, [3] walk_green, [4] walk_red
	logic [7:0]           m_axis_tdata;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [TIME_W-1:0]    cfg_data      = '0;

	pedestrian_traffic_light_fsm_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// controller mirror
	ptl_cfg_t            timing;
	logic [1:0]          ctl_phase;
	bit                  alt_flag;
	logic [TIME_W-1:0]   hold_len;
	logic [TIME_W-1:0]   since_service;
	bit                  in_blink;
	bit                  blink_on;
	logic [BLINK_W-1:0]  blinks_done;
	logic [LAMP_N-1:0]   lamp_state;

	bit                  tick_q[$];
	logic [LAMP_N-1:0]   lamp_q[$];
	string               lamp_name[LAMP_N] =
		'{"car_red", "car_yellow", "car_green", "walk_green", "walk_red"};

	int unsigned         fail_count = 0;
	int unsigned         tx_gap = 0;
	int unsigned         rx_wait = 0;
	int unsigned         rx_beats = 0;
	int unsigned         idle_cycles = 0;
	bit                  tx_calm = 1'b0;
	bit                  rx_calm = 1'b0;
	bit                  took;
	logic [LAMP_N-1:0]   want;

	function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
		case (idx)
			CFG_RED_TIME:     timing.red_time = val;
			CFG_YELLOW_TIME:  timing.yellow_time = val;
			CFG_GREEN_TIME:   timing.green_time = val;
			CFG_BLINK_PERIOD: timing.blink_period = val;
			CFG_BLINK_TOTAL:  timing.blink_total = val[BLINK_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void serve_red();
		lamp_state[LAMP_CAR_RED] = 1'b1;
		if (!in_blink) begin
			lamp_state[LAMP_WALK_GREEN] = 1'b1;
			hold_len = timing.red_time;
			in_blink = 1'b1;
			return;
		end
		blink_on = !blink_on;
		if (blink_on)
			lamp_state[LAMP_WALK_RED] = 1'b1;
		hold_len = timing.blink_period;
		if (!blink_on)
			blinks_done = blinks_done + 1'b1;
		if (blinks_done >= timing.blink_total) begin
			lamp_state[LAMP_WALK_RED] = 1'b1;
			blinks_done = '0;
			ctl_phase = PH_YELLOW;
			in_blink = 1'b0;
			blink_on = 1'b0;
		end
	endfunction

	function automatic void step_lights(bit button);
		if (button && alt_flag) begin
			ctl_phase = PH_YELLOW;
			hold_len = '0;
		end
		if (since_service >= hold_len) begin
			lamp_state = '0;
			case (ctl_phase)
				PH_YELLOW: begin
					lamp_state[LAMP_WALK_RED] = 1'b1;
					lamp_state[LAMP_CAR_YELLOW] = 1'b1;
					hold_len = timing.yellow_time;
					ctl_phase = alt_flag ? PH_RED : PH_GREEN;
					alt_flag = !alt_flag;
				end
				PH_GREEN: begin
					lamp_state[LAMP_WALK_RED] = 1'b1;
					lamp_state[LAMP_CAR_GREEN] = 1'b1;
					hold_len = timing.green_time;
					ctl_phase = PH_YELLOW;
				end
				default: serve_red();
			endcase
			since_service = 16'd1;
		end else if (since_service != ELAPSED_MAX) begin
			since_service = since_service + 1'b1;
		end
		lamp_q.push_back(lamp_state);
	endfunction

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// tick driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				step_lights(s_axis_tdata[0]);
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (tx_gap != 0) begin
					s_axis_tvalid <= 1'b0;
					tx_gap = tx_gap - 1;
				end else if (tick_q.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {7'b0, tick_q.pop_front()};
					tx_gap = pick_gap(tx_calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// lamp monitor and receiver
	always @(posedge clk) begin
		took = arst_n && m_axis_tvalid && m_axis_tready;
		if (took) begin
			if (lamp_q.size() == 0) begin
				$error("unexpected lamp beat %b", m_axis_tdata[LAMP_N-1:0]);
				fail_count++;
			end else begin
				want = lamp_q.pop_front();
				for (int i = 0; i < LAMP_N; i++) begin
					if (want[i] !== m_axis_tdata[i]) begin
						$error("%s expected %0d got %0d", lamp_name[i], want[i], m_axis_tdata[i]);
						fail_count++;
					end
				end
			end
			rx_beats++;
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (took && (rx_beats == 300 || rx_beats == 650)) begin
			m_axis_tready <= 1'b0;
			rx_wait = LONG_HOLD;
		end else if (rx_wait != 0) begin
			m_axis_tready <= 1'b0;
			rx_wait = rx_wait - 1;
		end else if (rx_calm || $urandom_range(0, 99) < 70) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			rx_wait = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(8, 30);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		load_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic write_timing(input logic [TIME_W-1:0] red, input logic [TIME_W-1:0] yellow,
			input logic [TIME_W-1:0] green, input logic [TIME_W-1:0] period,
			input logic [TIME_W-1:0] total);
		write_reg(CFG_RED_TIME, red);
		write_reg(CFG_YELLOW_TIME, yellow);
		write_reg(CFG_GREEN_TIME, green);
		write_reg(CFG_BLINK_PERIOD, period);
		write_reg(CFG_BLINK_TOTAL, total);
	endtask

	task automatic settle();
		while (tick_q.size() != 0 || s_axis_tvalid || lamp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic queue_ticks(input int unsigned count, input int unsigned press_pct);
		for (int unsigned i = 0; i < count; i++)
			tick_q.push_back($urandom_range(0, 99) < press_pct);
	endtask

	initial begin
		timing = '{red_time: RED_TIME_RST, yellow_time: YELLOW_TIME_RST,
			green_time: GREEN_TIME_RST, blink_period: BLINK_PERIOD_RST,
			blink_total: BLINK_TOTAL_RST};
		ctl_phase = PH_RED;
		alt_flag = 1'b0;
		hold_len = '0;
		since_service = '0;
		in_blink = 1'b0;
		blink_on = 1'b0;
		blinks_done = '0;
		lamp_state = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short timings, hand-placed presses
		write_timing(16'd2, 16'd1, 16'd2, 16'd1, 16'd1);
		write_reg(CFG_IDX_W'(CFG_BLINK_TOTAL + 1), 16'($urandom));
		for (int i = 0; i < 24; i++)
			tick_q.push_back(i == 1 || i == 7 || i == 8 || i == 12 || i == 16 || i == 17 ||
				i == 18 || i == 22);
		settle();

		// zero durations, blink count masked down to zero, unmapped indexes
		write_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFF0);
		for (int k = CFG_BLINK_TOTAL + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(k[CFG_IDX_W-1:0], 16'($urandom));
		queue_ticks(30, 30);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			tx_calm = (ph == 2 || ph == 5);
			rx_calm = (ph == 2 || ph == 5 || ph == 7);
			write_timing(16'($urandom_range(0, 12)), 16'($urandom_range(0, 8)),
				16'($urandom_range(0, 12)), 16'($urandom_range(0, 5)),
				(ph == 3) ? 16'd15 : (ph == 6) ? 16'd1 : 16'($urandom_range(1, 15)));
			queue_ticks(100, (ph % 3 == 0) ? 50 : 10);
			settle();
		end

		// longest timings last, so the long waits never block later settings
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		write_timing(ELAPSED_MAX, ELAPSED_MAX, ELAPSED_MAX, ELAPSED_MAX, 16'd15);
		queue_ticks(40, 20);
		settle();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
